[hw/rtl/mse_pkg.sv]
package mse_pkg;

  localparam int unsigned DataWords = 1024;
  localparam int unsigned DataAw = $clog2(DataWords);

  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpJ       = 6'h02;
  localparam logic [5:0] OpJal     = 6'h03;
  localparam logic [5:0] OpBeq     = 6'h04;
  localparam logic [5:0] OpBne     = 6'h05;
  localparam logic [5:0] OpBlez    = 6'h06;
  localparam logic [5:0] OpBgtz    = 6'h07;
  localparam logic [5:0] OpAddi    = 6'h08;
  localparam logic [5:0] OpLui     = 6'h0F;
  localparam logic [5:0] OpLw      = 6'h23;
  localparam logic [5:0] OpSw      = 6'h2B;

  localparam logic [5:0] FnSll  = 6'h00;
  localparam logic [5:0] FnSrl  = 6'h02;
  localparam logic [5:0] FnJr   = 6'h08;
  localparam logic [5:0] FnMfhi = 6'h10;
  localparam logic [5:0] FnMflo = 6'h12;
  localparam logic [5:0] FnMult = 6'h18;
  localparam logic [5:0] FnDiv  = 6'h1A;
  localparam logic [5:0] FnAdd  = 6'h20;
  localparam logic [5:0] FnSub  = 6'h22;
  localparam logic [5:0] FnAnd  = 6'h24;
  localparam logic [5:0] FnOr   = 6'h25;
  localparam logic [5:0] FnXor  = 6'h26;
  localparam logic [5:0] FnSlt  = 6'h2A;

  typedef struct packed {
    logic [31:0] instruction_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pc_after;
    logic        reg_written;
    logic [4:0]  reg_number;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
    logic        status;
  } out_item_t;

  // shared iterative unit control
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_rsp_t;

endpackage

[hw/rtl/mse_stream_if.sv]
interface mse_stream_if #(parameter int unsigned W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mips_subset_execute.sv]
// Flow: an accepted word passes through the read, execute and done states, and the
// done state registers the result onto the output. LW adds a memory state for the
// registered data memory read; MULT and DIV wait in the multiply/divide state for the
// one-bit-per-cycle shared multiply/divide unit. A new word is accepted only when idle; a
// pending result parks the next word in the read stage. Memory (1024 words) swept clear after reset.
// Async active-low reset clears registers, HI, LO, PC and program_base.
module mips_subset_execute (
  input  logic          clk_i,
  input  logic          rst_ni,
  mse_stream_if.sink    in_if,
  mse_stream_if.source  out_if,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i
);
  import mse_pkg::*;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StExec  = 3'd3;
  localparam logic [2:0] StMd    = 3'd4;
  localparam logic [2:0] StMem   = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [DataAw-1:0] clr_q, clr_d;
  logic [31:0] ir_q, ir_d;
  logic [31:0] a_q, b_q, a_d, b_d;
  logic [31:0] pc_q, pc_d, hi_q, hi_d, lo_q, lo_d, base_q;
  logic [31:0] rf_q [32];
  logic        ovld_q, ovld_d;
  out_item_t   out_q, out_d;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic        ram_we;
  logic [DataAw-1:0] ram_wa, ram_ra;
  logic [31:0] ram_wd, ram_rd;
  md_req_t     md_req;
  md_rsp_t     md_rsp;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] simm, addr, pc4, shr;
  assign op   = ir_q[31:26];
  assign rs   = ir_q[25:21];
  assign rt   = ir_q[20:16];
  assign rd   = ir_q[15:11];
  assign sa   = ir_q[10:6];
  assign fn   = ir_q[5:0];
  assign simm = {{16{ir_q[15]}}, ir_q[15:0]};
  assign addr = a_q + simm;
  assign pc4  = pc_q + 32'd4;
  assign shr  = b_q >> sa;

  mse_ram #(.Width(32), .Depth(DataWords)) u_dmem (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  mse_muldiv u_md (.clk_i, .rst_ni, .req_i(md_req), .rsp_o(md_rsp));

  assign in_if.ready  = (state_q == StIdle);
  assign out_if.valid = ovld_q;
  assign out_if.data  = out_q;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    ir_d    = ir_q;
    a_d     = a_q;
    b_d     = b_q;
    pc_d    = pc_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    ovld_d  = ovld_q;
    out_d   = out_q;
    rf_we   = 1'b0;
    rf_wa   = rd;
    rf_wd   = '0;
    ram_we  = 1'b0;
    ram_wa  = addr[DataAw-1:0];
    ram_wd  = b_q;
    ram_ra  = addr[DataAw-1:0];
    md_req  = '{start: 1'b0, is_div: (fn == FnDiv), a: a_q, b: b_q};

    if (ovld_q && out_if.ready) ovld_d = 1'b0;

    unique case (state_q)
      StClear: begin
        ram_we = 1'b1;
        ram_wa = clr_q;
        ram_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == DataAw'(DataWords - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (in_if.valid && in_if.ready) begin
          ir_d    = in_if.data;
          state_d = StRead;
        end
      end
      StRead: begin
        a_d     = rf_q[rs];
        b_d     = rf_q[rt];
        // wait here while the previous transaction is still pending
        if (!ovld_q || out_if.ready) state_d = StExec;
      end
      StExec: begin
        out_d    = '0;
        out_d.status = 1'b0;
        state_d  = StDone;
        if (ir_q == '0) begin
          pc_d = pc4;
        end else if (op == OpSpecial) begin
          rf_wa = rd;
          pc_d  = pc4;
          case (fn)
            FnAdd:  begin rf_we = 1'b1; rf_wd = a_q + b_q; end
            FnSub:  begin rf_we = 1'b1; rf_wd = a_q - b_q; end
            FnAnd:  begin rf_we = 1'b1; rf_wd = a_q & b_q; end
            FnOr:   begin rf_we = 1'b1; rf_wd = a_q | b_q; end
            FnXor:  begin rf_we = 1'b1; rf_wd = a_q ^ b_q; end
            FnSlt:  begin
              rf_we = 1'b1;
              rf_wd = {31'd0, $signed(a_q) < $signed(b_q)};
            end
            FnSll:  begin rf_we = 1'b1; rf_wd = b_q << sa; end
            FnSrl:  begin
              rf_we = 1'b1;
              rf_wd = ir_q[21] ? (shr | (b_q << (6'd32 - {1'b0, sa}))) : shr;
            end
            FnMfhi: begin rf_we = 1'b1; rf_wd = hi_q; end
            FnMflo: begin rf_we = 1'b1; rf_wd = lo_q; end
            FnMult, FnDiv: begin
              md_req.start = 1'b1;
              state_d      = StMd;
            end
            FnJr:   pc_d = a_q + base_q + 32'd4;
            default: begin
              pc_d = pc_q;
              out_d.status = 1'b1;
            end
          endcase
        end else begin
          rf_wa = rt;
          pc_d  = pc4;
          case (op)
            OpAddi: begin rf_we = 1'b1; rf_wd = a_q + simm; end
            OpBeq:  if (a_q == b_q) pc_d = pc4 + {simm[29:0], 2'b00};
            OpBne:  if (a_q != b_q) pc_d = pc4 + {simm[29:0], 2'b00};
            OpBgtz: if (!a_q[31] && a_q != '0) pc_d = pc4 + {simm[29:0], 2'b00};
            OpBlez: if (a_q[31] || a_q == '0) pc_d = pc4 + {simm[29:0], 2'b00};
            OpLui:  begin rf_we = 1'b1; rf_wd = {ir_q[15:0], 16'd0}; end
            OpLw:   state_d = StMem;
            OpSw:   begin ram_we = 1'b1; out_d.mem_written = 1'b1; end
            OpJ:    pc_d = {6'd0, ir_q[25:0]};
            OpJal:  begin
              rf_we = 1'b1; rf_wa = 5'd31; rf_wd = pc4;
              pc_d  = {6'd0, ir_q[25:0]};
            end
            default: begin
              pc_d = pc_q;
              out_d.status = 1'b1;
            end
          endcase
        end
        if (rf_wa == 5'd0) rf_we = 1'b0;
        out_d.reg_written = rf_we;
        out_d.reg_number  = rf_we ? rf_wa : 5'd0;
        out_d.reg_value   = rf_we ? rf_wd : 32'd0;
      end
      StMd: begin
        if (md_rsp.done) begin
          hi_d    = md_rsp.hi;
          lo_d    = md_rsp.lo;
          state_d = StDone;
        end
      end
      StMem: begin
        rf_wa = rt;
        rf_wd = ram_rd;
        rf_we = (rt != 5'd0);
        out_d.reg_written = rf_we;
        out_d.reg_number  = rf_we ? rt : 5'd0;
        out_d.reg_value   = rf_we ? ram_rd : 32'd0;
        state_d = StDone;
      end
      StDone: begin
        out_d.pc_after = pc_q;
        out_d.hi_value = hi_q;
        out_d.lo_value = lo_q;
        ovld_d  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      pc_q    <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
      base_q  <= '0;
      ovld_q  <= 1'b0;
      for (int i = 0; i < 32; i++) rf_q[i] <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pc_q    <= pc_d;
      hi_q    <= hi_d;
      lo_q    <= lo_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) base_q <= cfg_wdata_i;
      if (rf_we) rf_q[rf_wa] <= rf_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q  <= ir_d;
    a_q   <= a_d;
    b_q   <= b_d;
    out_q <= out_d;
  end
endmodule

[hw/rtl/mse_ram.sv]
module mse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/mse_muldiv.sv]
// Radix-2 shift/add multiplier and restoring divider, one bit per cycle.
module mse_muldiv (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mse_pkg::md_req_t req_i,
  output mse_pkg::md_rsp_t rsp_o
);
  import mse_pkg::*;

  logic        busy_q, busy_d;
  logic        div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;   // HI side
  logic [31:0] lo_q, lo_d;     // multiplier / dividend -> quotient
  logic [31:0] b_q, b_d;
  logic [32:0] sum;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  always_comb begin
    sum    = {1'b0, acc_q} + (lo_q[0] ? {1'b0, b_q} : 33'd0);
    rem_sh = {acc_q, lo_q[31]};
    diff   = rem_sh - {1'b0, b_q};
  end

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    lo_d   = lo_q;
    b_d    = b_q;
    rsp_o.done = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      div_d  = req_i.is_div;
      cnt_d  = 6'd0;
      acc_d  = '0;
      lo_d   = req_i.a;
      b_d    = req_i.b;
    end else if (busy_q) begin
      if (div_q) begin
        if (!diff[32]) begin
          acc_d = diff[31:0];
          lo_d  = {lo_q[30:0], 1'b1};
        end else begin
          acc_d = rem_sh[31:0];
          lo_d  = {lo_q[30:0], 1'b0};
        end
      end else begin
        acc_d = sum[32:1];
        lo_d  = {sum[0], lo_q[31:1]};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d     = 1'b0;
        rsp_o.done = 1'b1;
      end
    end
    // divide by zero naturally yields quotient all ones and remainder a
    rsp_o.hi = acc_d;
    rsp_o.lo = lo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    lo_q  <= lo_d;
    b_q   <= b_d;
  end
endmodule

[hw/rtl/mse_checker.sv]
module mse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_pc_i,
  input logic [31:0] out_lo_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pc_i) && $stable(out_lo_i))
    else $error("result changed while stalled");

  a_hs_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(in_ready_i) && !$isunknown(out_valid_i))
    else $error("handshake unknown");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("accepted back to back");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i) ##1 !$rose(out_valid_i))
    else $error("result too early");
endmodule

bind mips_subset_execute mse_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_pc_i(out_if.data[135:104]), .out_lo_i(out_if.data[32:1])
);

[tb/tb_mips_subset_execute.sv]
`timescale 1ns / 100ps

module tb_mips_subset_execute;
  import mse_pkg::*;

  localparam int unsigned StallLimit = 5000;

  typedef struct {
    logic [31:0] word;
    bit          typed;
    out_item_t   result;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [31:0] cfg_wdata_i;

  mse_stream_if #(.W($bits(in_item_t)))  in_ch ();
  mse_stream_if #(.W($bits(out_item_t))) out_ch ();

  mips_subset_execute u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // architectural shadow state
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q, pc_q, base_q;
  logic [31:0] dmem [DataWords];

  out_item_t exp_results [$];
  int unsigned fails;
  bit idle_en;
  int unsigned hold_cycles;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  function automatic logic [31:0] r_type(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sa);
    return {OpSpecial, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // executes one word on the shadow state, returns the expected transaction
  function automatic out_item_t exec_word(logic [31:0] w);
    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rs, rt, rd, sa, dst;
    logic [31:0] simm, a, b, npc, val;
    logic [63:0] prod;
    bit bad, wr, mw;
    out_item_t r;
    op = w[31:26];
    rs = w[25:21];
    rt = w[20:16];
    rd = w[15:11];
    sa = w[10:6];
    fn = w[5:0];
    simm = {{16{w[15]}}, w[15:0]};
    a = gpr[rs];
    b = gpr[rt];
    npc = pc_q + 32'd4;
    bad = 0;
    wr = 0;
    mw = 0;
    dst = 0;
    val = 0;
    if (w == 32'd0) begin
    end else if (op == OpSpecial) begin
      dst = rd;
      wr = 1;
      case (fn)
        FnAdd: val = a + b;
        FnSub: val = a - b;
        FnAnd: val = a & b;
        FnOr: val = a | b;
        FnXor: val = a ^ b;
        FnSlt: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        FnSll: val = b << sa;
        FnSrl: begin
          if (w[21] && sa != 0) val = (b >> sa) | (b << (6'd32 - sa));
          else if (w[21]) val = b;
          else val = b >> sa;
        end
        FnMfhi: val = hi_q;
        FnMflo: val = lo_q;
        FnMult: begin
          prod = {32'd0, a} * {32'd0, b};
          hi_q = prod[63:32];
          lo_q = prod[31:0];
          wr = 0;
        end
        FnDiv: begin
          if (b == 0) begin
            lo_q = '1;
            hi_q = a;
          end else begin
            lo_q = a / b;
            hi_q = a % b;
          end
          wr = 0;
        end
        FnJr: begin
          npc = a + base_q + 32'd4;
          wr = 0;
        end
        default: begin
          bad = 1;
          wr = 0;
        end
      endcase
    end else begin
      dst = rt;
      case (op)
        OpAddi: begin wr = 1; val = a + simm; end
        OpBeq: if (a == b) npc += simm << 2;
        OpBne: if (a != b) npc += simm << 2;
        OpBgtz: if ($signed(a) > 0) npc += simm << 2;
        OpBlez: if ($signed(a) <= 0) npc += simm << 2;
        OpLui: begin wr = 1; val = {w[15:0], 16'd0}; end
        OpLw: begin wr = 1; val = dmem[(a + simm) % DataWords]; end
        OpSw: begin dmem[(a + simm) % DataWords] = b; mw = 1; end
        OpJ: npc = {6'd0, w[25:0]};
        OpJal: begin
          wr = 1;
          dst = 5'd31;
          val = pc_q + 32'd4;
          npc = {6'd0, w[25:0]};
        end
        default: bad = 1;
      endcase
    end
    if (wr && dst == 0) wr = 0;
    if (wr) gpr[dst] = val;
    else begin
      dst = 0;
      val = 0;
    end
    if (!bad) pc_q = npc;
    r.pc_after = pc_q;
    r.reg_written = wr;
    r.reg_number = dst;
    r.reg_value = val;
    r.mem_written = mw;
    r.hi_value = hi_q;
    r.lo_value = lo_q;
    r.status = bad;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    logic [5:0] fns [13] = '{FnAdd, FnSub, FnAnd, FnOr, FnXor, FnSlt, FnSll, FnSrl,
                             FnMfhi, FnMflo, FnMult, FnDiv, FnJr};
    logic [5:0] ops [10] = '{OpAddi, OpLui, OpLw, OpSw, OpBeq, OpBne, OpBgtz, OpBlez,
                             OpJ, OpJal};
    logic [31:0] w;
    int unsigned k;
    w = $urandom;
    k = $urandom_range(99);
    // mix raw random words, SPECIAL words with any function code, supported SPECIAL functions and I/J opcodes
    if (k < 8) return w;
    if (k < 12) return {OpSpecial, w[25:6], 6'($urandom_range(63))};
    if (k < 55) return {OpSpecial, w[25:6], fns[$urandom_range(12)]};
    return {ops[$urandom_range(9)], w[25:0]};
  endfunction

  task automatic send(logic [31:0] w, bit typed, out_item_t result);
    out_item_t pred;
    if (idle_en && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = exec_word(w);
    exp_results.push_back(typed ? result : pred);
  endtask

  task automatic drain();
    @(posedge clk_i);
    in_ch.valid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_base(logic [31:0] v);
    drain();
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    base_q = v;
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, e, a);
      fails++;
    end
  endtask

  // result side: sample, compare, then drive ready
  initial begin
    out_item_t got, want;
    int unsigned held;
    held = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (exp_results.size() == 0) begin
          $display("%0t unexpected transaction expected none actual %h", $time, got);
          fails++;
        end else begin
          want = exp_results.pop_front();
          check_field("pc_after", want.pc_after, got.pc_after);
          check_field("reg_written", want.reg_written, got.reg_written);
          check_field("reg_number", want.reg_number, got.reg_number);
          check_field("reg_value", want.reg_value, got.reg_value);
          check_field("mem_written", want.mem_written, got.mem_written);
          check_field("hi_value", want.hi_value, got.hi_value);
          check_field("lo_value", want.lo_value, got.lo_value);
          check_field("status", want.status, got.status);
        end
      end
      if (hold_cycles != 0 && held == 0) held = hold_cycles;
      if (held != 0) begin
        held--;
        if (held == 0) hold_cycles = 0;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= idle_en ? ($urandom_range(99) >= 38) : 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL mips_subset_execute");
      $finish;
    end
  end

  initial begin
    dir_row_t rows [$];
    out_item_t none;
    none = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    fails = 0;
    idle_en = 1;
    hold_cycles = 0;
    quiet_cycles = 0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    hi_q = 0;
    lo_q = 0;
    pc_q = 0;
    base_q = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_base(32'hFFFF_FFFF);
    rows.push_back('{32'd0, 1, '{32'd4, 0, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{32'hFFFF_FFFF, 1, '{32'd4, 0, 0, 0, 0, 0, 0, 1}});
    rows.push_back('{i_type(OpLui, 0, 1, 16'hFFFF), 1,
                     '{32'd8, 1, 5'd1, 32'hFFFF_0000, 0, 0, 0, 0}});
    rows.push_back('{r_type(FnDiv, 1, 0, 0, 0), 1,
                     '{32'd12, 0, 0, 0, 0, 32'hFFFF_0000, 32'hFFFF_FFFF, 0}});
    rows.push_back('{i_type(OpAddi, 1, 2, 16'hFFFF), 0, none});
    rows.push_back('{i_type(OpAddi, 0, 0, 16'h7FFF), 0, none});
    rows.push_back('{i_type(OpAddi, 0, 3, 16'h8000), 0, none});
    rows.push_back('{r_type(FnMult, 2, 2, 0, 0), 0, none});
    rows.push_back('{r_type(FnMfhi, 0, 0, 4, 0), 0, none});
    rows.push_back('{r_type(FnMflo, 0, 0, 5, 0), 0, none});
    rows.push_back('{r_type(FnDiv, 2, 3, 0, 0), 0, none});
    rows.push_back('{r_type(FnSll, 0, 2, 6, 5'd31), 0, none});
    rows.push_back('{r_type(FnSrl, 0, 2, 7, 5'd31), 0, none});
    rows.push_back('{r_type(FnSrl, 1, 3, 8, 5'd0), 0, none});
    rows.push_back('{r_type(FnSrl, 1, 3, 9, 5'd31), 0, none});
    rows.push_back('{r_type(FnSub, 0, 2, 10, 0), 0, none});
    rows.push_back('{r_type(FnSlt, 3, 2, 11, 0), 0, none});
    rows.push_back('{r_type(FnXor, 2, 3, 12, 0) | r_type(FnAnd, 0, 0, 0, 0), 0, none});
    rows.push_back('{i_type(OpSw, 3, 2, 16'h8000), 0, none});
    rows.push_back('{i_type(OpLw, 3, 13, 16'h8000), 0, none});
    rows.push_back('{i_type(OpBeq, 0, 0, 16'h8000), 0, none});
    rows.push_back('{i_type(OpBne, 2, 0, 16'h7FFF), 0, none});
    rows.push_back('{i_type(OpBgtz, 2, 0, 16'h0004), 0, none});
    rows.push_back('{i_type(OpBlez, 2, 0, 16'hFFFC), 0, none});
    rows.push_back('{{OpJal, 26'h3FF_FFFF}, 0, none});
    rows.push_back('{r_type(FnJr, 31, 0, 0, 0), 0, none});
    foreach (rows[i]) send(rows[i].word, rows[i].typed, rows[i].result);

    write_base(32'd0);
    for (int i = 0; i < 275; i++) begin
      if (i == 100) hold_cycles = 300;
      send(rand_word(), 0, none);
    end
    write_base($urandom);
    idle_en = 0;
    for (int i = 0; i < 275; i++) send(rand_word(), 0, none);
    idle_en = 1;
    write_base(32'h8000_0000);
    for (int i = 0; i < 275; i++) begin
      if (i == 150) drain();
      send(rand_word(), 0, none);
    end
    write_base($urandom);
    for (int i = 0; i < 275; i++) send(rand_word(), 0, none);
    drain();
    repeat (50) @(posedge clk_i);
    if (fails == 0) $display("PASS mips_subset_execute");
    else $display("FAIL mips_subset_execute");
    $finish;
  end

endmodule
